@@ src/hdf_pkg.sv @@
`default_nettype none
package hdf_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int FIELD_W      = 32;
    localparam int HASH_W       = 32;

    localparam int HASH_MUL_A = 43;
    localparam int HASH_MUL_B = 73;
    localparam int PROBE_STEP = 5009;

    localparam logic [HASH_W-1:0] HASH_MUL = HASH_W'(HASH_MUL_A * HASH_MUL_B);

    typedef struct packed {
        logic [FIELD_W-1:0] pos_a;
        logic [FIELD_W-1:0] pos_b;
        logic [FIELD_W-1:0] run_length;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_QUOT,
        S_MOD,
        S_FOLD,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

@@ src/hdf_ram.sv @@
`default_nettype none
module hdf_ram #(
    parameter int WIDTH = hdf_pkg::SLOT_W,
    parameter int DEPTH = hdf_pkg::DEF_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/hash_dedup_filter_core.sv @@
`default_nettype none
// An accepted beat passes S_HASH, S_READ, S_CMP and S_EMIT; each further probe repeats
// S_READ and S_CMP, a zero-length beat goes from S_HASH to S_EMIT, and a CAPACITY that is
// not a power of two adds S_QUOT, S_MOD and S_FOLD (reciprocal modulo in the shared multiplier).
// One beat in flight; the next is taken the cycle after S_EMIT loads the output registers.
// Reset is synchronous, active low; after reset and after each end-of-list beat the
// table is swept to empty slot by slot, during which input is stalled.
module hash_dedup_filter_core #(
    parameter int CAPACITY = hdf_pkg::DEF_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_pos_a,
    input  wire logic [31:0] i_pos_b,
    input  wire logic [31:0] i_run_length,
    input  wire logic        i_last_of_list,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_keep,
    output logic      [31:0] o_out_pos_a,
    output logic      [31:0] o_out_pos_b,
    output logic      [31:0] o_out_length,
    output logic             o_overflow,
    output logic             o_end_of_list
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int STEP    = hdf_pkg::PROBE_STEP % CAPACITY;
    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int HW      = hdf_pkg::HASH_W;
    localparam logic [HW-1:0] RECIP = HW'((64'd1 << HW) / 64'(CAPACITY));

    hdf_pkg::t_state r_state, n_state;

    logic [31:0]      r_pos_a, n_pos_a;
    logic [31:0]      r_pos_b, n_pos_b;
    logic [31:0]      r_len, n_len;
    logic             r_last, n_last;
    logic [HW-1:0]    r_hash, n_hash;
    logic [HW-1:0]    r_quot, n_quot;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_probe, n_probe;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_keep, n_keep;
    logic             r_ovf, n_ovf;

    logic             r_o_valid, n_o_valid;
    logic             r_o_keep, n_o_keep;
    logic [31:0]      r_o_pos_a, n_o_pos_a;
    logic [31:0]      r_o_pos_b, n_o_pos_b;
    logic [31:0]      r_o_len, n_o_len;
    logic             r_o_ovf, n_o_ovf;
    logic             r_o_eol, n_o_eol;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    hdf_pkg::t_slot              ram_wdata;
    logic                        ram_re;
    hdf_pkg::t_slot              ram_rdata;

    logic [HW-1:0]    w_mul_a;
    logic [HW-1:0]    w_mul_b;
    logic [2*HW-1:0]  w_mul;
    logic [IDX_W:0]   w_opnd;
    logic [IDX_W:0]   w_red_full;
    logic [IDX_W-1:0] w_red;
    logic             w_empty;
    logic             w_match;
    logic             w_out_free;

    hdf_ram #(
        .WIDTH (hdf_pkg::SLOT_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign w_empty    = ram_rdata.run_length == '0;
    assign w_match    = (ram_rdata.pos_a == r_pos_a) && (ram_rdata.pos_b == r_pos_b)
                     && (ram_rdata.run_length == r_len);
    assign w_out_free = !r_o_valid || !i_stall;

    // shared multiplier: hash scale, reciprocal quotient, quotient times capacity
    always_comb begin
        case (r_state)
            hdf_pkg::S_QUOT: begin
                w_mul_a = r_hash;
                w_mul_b = RECIP;
            end
            hdf_pkg::S_MOD: begin
                w_mul_a = r_quot;
                w_mul_b = HW'(CAPACITY);
            end
            default: begin
                w_mul_a = r_hash;
                w_mul_b = hdf_pkg::HASH_MUL;
            end
        endcase
        w_mul = w_mul_a * w_mul_b;
    end

    // shared reduce unit: operand below 2*CAPACITY, one compare and subtract
    always_comb begin
        if (r_state == hdf_pkg::S_FOLD) begin
            w_opnd = r_hash[IDX_W:0];
        end else begin
            w_opnd = {1'b0, r_idx} + (IDX_W + 1)'(STEP);
        end
        if (w_opnd >= (IDX_W + 1)'(CAPACITY)) begin
            w_red_full = w_opnd - (IDX_W + 1)'(CAPACITY);
        end else begin
            w_red_full = w_opnd;
        end
        w_red = w_red_full[IDX_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hdf_pkg::S_CLEAR: begin
                if (r_clr == IDX_W'(CAPACITY - 1)) begin
                    n_state = hdf_pkg::S_IDLE;
                end
            end
            hdf_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = hdf_pkg::S_HASH;
                end
            end
            hdf_pkg::S_HASH: begin
                if (r_len == '0) begin
                    n_state = hdf_pkg::S_EMIT;
                end else if (IS_POW2) begin
                    n_state = hdf_pkg::S_READ;
                end else begin
                    n_state = hdf_pkg::S_QUOT;
                end
            end
            hdf_pkg::S_QUOT: begin
                n_state = hdf_pkg::S_MOD;
            end
            hdf_pkg::S_MOD: begin
                n_state = hdf_pkg::S_FOLD;
            end
            hdf_pkg::S_FOLD: begin
                n_state = hdf_pkg::S_READ;
            end
            hdf_pkg::S_READ: begin
                n_state = hdf_pkg::S_CMP;
            end
            hdf_pkg::S_CMP: begin
                if (w_empty || w_match || (r_probe == IDX_W'(CAPACITY - 1))) begin
                    n_state = hdf_pkg::S_EMIT;
                end else begin
                    n_state = hdf_pkg::S_READ;
                end
            end
            hdf_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_last ? hdf_pkg::S_CLEAR : hdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hdf_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_pos_a   = r_pos_a;
        n_pos_b   = r_pos_b;
        n_len     = r_len;
        n_last    = r_last;
        n_hash    = r_hash;
        n_quot    = r_quot;
        n_idx     = r_idx;
        n_probe   = r_probe;
        n_clr     = r_clr;
        n_count   = r_count;
        n_keep    = r_keep;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid && i_stall;
        n_o_keep  = r_o_keep;
        n_o_pos_a = r_o_pos_a;
        n_o_pos_b = r_o_pos_b;
        n_o_len   = r_o_len;
        n_o_ovf   = r_o_ovf;
        n_o_eol   = r_o_eol;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '{pos_a: r_pos_a, pos_b: r_pos_b, run_length: r_len};
        ram_re    = 1'b0;
        o_stall   = 1'b1;
        case (r_state)
            hdf_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + IDX_W'(1);
            end
            hdf_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_pos_a = i_pos_a;
                    n_pos_b = i_pos_b;
                    n_len   = i_run_length;
                    n_last  = i_last_of_list;
                    n_hash  = i_pos_a + i_pos_b + i_run_length;
                    n_keep  = 1'b1;
                    n_ovf   = 1'b0;
                    n_probe = '0;
                end
            end
            hdf_pkg::S_HASH: begin
                n_hash = w_mul[HW-1:0];
                if (IS_POW2) begin
                    n_idx = w_mul[IDX_W-1:0];
                end
            end
            hdf_pkg::S_QUOT: begin
                n_quot = w_mul[2*HW-1:HW];
            end
            hdf_pkg::S_MOD: begin
                n_hash = r_hash - w_mul[HW-1:0];
            end
            hdf_pkg::S_FOLD: begin
                n_idx = w_red;
            end
            hdf_pkg::S_READ: begin
                ram_re = 1'b1;
            end
            hdf_pkg::S_CMP: begin
                if (w_match) begin
                    n_keep = 1'b0;
                end else if (w_empty) begin
                    if (r_count < CNT_W'(CAPACITY)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (r_probe == IDX_W'(CAPACITY - 1)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_idx   = w_red;
                    n_probe = r_probe + IDX_W'(1);
                end
            end
            hdf_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_keep  = r_keep;
                    n_o_pos_a = r_pos_a;
                    n_o_pos_b = r_pos_b;
                    n_o_len   = r_len;
                    n_o_ovf   = r_ovf;
                    n_o_eol   = r_last;
                    if (r_last) begin
                        n_count = '0;
                        n_clr   = '0;
                    end
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hdf_pkg::S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_a   <= n_pos_a;
        r_pos_b   <= n_pos_b;
        r_len     <= n_len;
        r_last    <= n_last;
        r_hash    <= n_hash;
        r_quot    <= n_quot;
        r_idx     <= n_idx;
        r_probe   <= n_probe;
        r_keep    <= n_keep;
        r_ovf     <= n_ovf;
        r_o_keep  <= n_o_keep;
        r_o_pos_a <= n_o_pos_a;
        r_o_pos_b <= n_o_pos_b;
        r_o_len   <= n_o_len;
        r_o_ovf   <= n_o_ovf;
        r_o_eol   <= n_o_eol;
    end

    assign o_valid       = r_o_valid;
    assign o_keep        = r_o_keep;
    assign o_out_pos_a   = r_o_pos_a;
    assign o_out_pos_b   = r_o_pos_b;
    assign o_out_length  = r_o_len;
    assign o_overflow    = r_o_ovf;
    assign o_end_of_list = r_o_eol;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hdf_pkg::S_CMP && ram_we) |-> (w_empty && !w_match && r_len != '0))
        else $error("insert into occupied slot");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hdf_pkg::S_EMIT && w_out_free && r_last)
            |=> (r_state == hdf_pkg::S_CLEAR && r_count == '0 && r_clr == '0))
        else $error("end of list did not start a clear sweep");

    a_dup_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && !o_keep))
        else $error("duplicate flagged as overflow");

    a_zero_len_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_length == '0) |-> (o_keep && !o_overflow))
        else $error("zero length beat not kept cleanly");
`endif

endmodule
`default_nettype wire

@@ sim/hash_dedup_filter_core_tb.sv @@
`timescale 1ns / 1ps
module hash_dedup_filter_core_tb;

    localparam int CAP          = hdf_pkg::DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 540;
    localparam int FILL_ITEMS   = 128;
    localparam int IDLE_LIMIT   = 20000;
    localparam int TAIL_CYCLES  = CAP + 200;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        logic [31:0] pos_a;
        logic [31:0] pos_b;
        logic [31:0] run_length;
        logic        last;
    } triple_t;

    typedef struct {
        logic        keep;
        logic [31:0] pos_a;
        logic [31:0] pos_b;
        logic [31:0] length;
        logic        overflow;
        logic        end_of_list;
    } verdict_t;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [31:0] i_pos_a        = '0;
    logic [31:0] i_pos_b        = '0;
    logic [31:0] i_run_length   = '0;
    logic        i_last_of_list = 1'b0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_keep;
    logic [31:0] o_out_pos_a;
    logic [31:0] o_out_pos_b;
    logic [31:0] o_out_length;
    logic        o_overflow;
    logic        o_end_of_list;

    triple_t     pending_triples[$];
    verdict_t    expected_verdicts[$];

    hdf_pkg::t_slot shadow_slots [CAP] = '{default: '0};
    int             shadow_count = 0;

    int unsigned total_beats    = 0;
    int unsigned accepted_beats = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned idle_cycles    = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    stall_mode_t stall_mode   = STALL_NONE;
    int unsigned stall_left   = 0;
    int unsigned stall_tick   = 0;
    int unsigned stall_period = 4;
    int unsigned stall_duty   = 1;

    hash_dedup_filter_core #(
        .CAPACITY(CAP)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pos_a       (i_pos_a),
        .i_pos_b       (i_pos_b),
        .i_run_length  (i_run_length),
        .i_last_of_list(i_last_of_list),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_keep        (o_keep),
        .o_out_pos_a   (o_out_pos_a),
        .o_out_pos_b   (o_out_pos_b),
        .o_out_length  (o_out_length),
        .o_overflow    (o_overflow),
        .o_end_of_list (o_end_of_list)
    );

    always #10 i_clk = ~i_clk;

    function automatic verdict_t dedup_lookup(triple_t t);
        verdict_t    v;
        logic [31:0] h;
        int          idx;
        int          n;
        bit          hit;
        bit          hole;
        v.keep        = 1'b1;
        v.pos_a       = t.pos_a;
        v.pos_b       = t.pos_b;
        v.length      = t.run_length;
        v.overflow    = 1'b0;
        v.end_of_list = t.last;
        hit  = 1'b0;
        hole = 1'b0;
        if (t.run_length != 0) begin
            h   = t.pos_a + t.pos_b + t.run_length;
            h   = h * 32'(hdf_pkg::HASH_MUL_A);
            h   = h * 32'(hdf_pkg::HASH_MUL_B);
            idx = int'(h % 32'(CAP));
            for (n = 0; n < CAP && !hit && !hole; n++) begin
                if (shadow_slots[idx].run_length == 0) begin
                    hole = 1'b1;
                end else if (shadow_slots[idx].pos_a == t.pos_a &&
                             shadow_slots[idx].pos_b == t.pos_b &&
                             shadow_slots[idx].run_length == t.run_length) begin
                    hit = 1'b1;
                end else begin
                    idx = (idx + hdf_pkg::PROBE_STEP) % CAP;
                end
            end
            if (hit) begin
                v.keep = 1'b0;
            end else if (hole && shadow_count < CAP) begin
                shadow_slots[idx] = '{pos_a: t.pos_a, pos_b: t.pos_b, run_length: t.run_length};
                shadow_count++;
            end else begin
                v.overflow = 1'b1;
            end
        end
        if (t.last) begin
            foreach (shadow_slots[k]) shadow_slots[k] = '0;
            shadow_count = 0;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // sender: bursts of beats separated by random gaps
    always @(posedge i_clk) begin : drive
        triple_t nxt;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_verdicts.push_back(dedup_lookup(
                    triple_t'{i_pos_a, i_pos_b, i_run_length, i_last_of_list}));
                accepted_beats <= accepted_beats + 1;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    i_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_triples.size() > 0) begin
                    nxt = pending_triples.pop_front();
                    i_valid        <= 1'b1;
                    i_pos_a        <= nxt.pos_a;
                    i_pos_b        <= nxt.pos_b;
                    i_run_length   <= nxt.run_length;
                    i_last_of_list <= nxt.last;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        case ($urandom_range(0, 5))
                            0, 1: gap_left <= 0;
                            5: gap_left <= $urandom_range(20, 40);
                            default: gap_left <= $urandom_range(1, 8);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern that changes mode at random intervals
    always @(posedge i_clk) begin : recv_pattern
        int unsigned p;
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            stall_mode   <= STALL_NONE;
            stall_left   <= 0;
            stall_tick   <= 0;
            stall_period <= 4;
            stall_duty   <= 1;
        end else begin
            if (stall_left == 0) begin
                p = $urandom_range(2, 16);
                stall_mode   <= stall_mode_t'($urandom_range(0, 3));
                stall_left   <= $urandom_range(50, 400);
                stall_period <= p;
                stall_duty   <= $urandom_range(1, p - 1);
            end else begin
                stall_left <= stall_left - 1;
            end
            stall_tick <= stall_tick + 1;
            case (stall_mode)
                STALL_NONE: i_stall <= 1'b0;
                STALL_SPARSE: i_stall <= ($urandom_range(0, 99) < 30);
                STALL_PERIODIC: i_stall <= ((stall_tick % stall_period) < stall_duty);
                default: i_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    always @(posedge i_clk) begin : check
        verdict_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with nothing expected, pos_a", o_out_pos_a, '0);
            end else begin
                want = expected_verdicts.pop_front();
                if (o_keep !== want.keep) begin
                    report_mismatch("keep", 32'(o_keep), 32'(want.keep));
                end
                if (o_out_pos_a !== want.pos_a) report_mismatch("pos_a", o_out_pos_a, want.pos_a);
                if (o_out_pos_b !== want.pos_b) report_mismatch("pos_b", o_out_pos_b, want.pos_b);
                if (o_out_length !== want.length) begin
                    report_mismatch("length", o_out_length, want.length);
                end
                if (o_overflow !== want.overflow) begin
                    report_mismatch("overflow", 32'(o_overflow), 32'(want.overflow));
                end
                if (o_end_of_list !== want.end_of_list) begin
                    report_mismatch("end_of_list", 32'(o_end_of_list),
                                    32'(want.end_of_list));
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("hash_dedup_filter_core regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        triple_t     t;
        triple_t     base;
        triple_t     list_seen[$];
        int unsigned random_items;
        int unsigned list_len;
        int unsigned pick;
        int unsigned j;
        int          k;
        logic [31:0] key;

        // zero lengths, extremes, probe chains, wraparound of the sum, clear
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h0, 1'b0});
        pending_triples.push_back(triple_t'{32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 1'b0});
        pending_triples.push_back(triple_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
        pending_triples.push_back(triple_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h1, 1'b0});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h401, 1'b0});
        pending_triples.push_back(triple_t'{32'h1, 32'h0, 32'h400, 1'b0});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h401, 1'b0});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h1, 1'b0});
        pending_triples.push_back(triple_t'{32'h8000_0000, 32'h8000_0000, 32'h401, 1'b0});
        pending_triples.push_back(triple_t'{32'h8000_0000, 32'h8000_0000, 32'h401, 1'b0});
        pending_triples.push_back(triple_t'{32'hAAAA_AAAA, 32'h5555_5555, 32'h5A5A_5A5A, 1'b0});
        pending_triples.push_back(triple_t'{32'h5555_5555, 32'hAAAA_AAAA, 32'hA5A5_A5A5, 1'b0});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h1, 1'b1});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h1, 1'b0});
        pending_triples.push_back(triple_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
        pending_triples.push_back(triple_t'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 1'b1});
        pending_triples.push_back(triple_t'{32'h0, 32'h0, 32'h1, 1'b1});

        // one long probe chain: equal low sum bits share a home slot
        list_seen.delete();
        for (k = 0; k < FILL_ITEMS; k++) begin
            t.pos_a      = $urandom;
            t.pos_b      = $urandom;
            t.run_length = ($urandom & 32'hFFFF_FC00) |
                           ((32'h0000_0155 - t.pos_a - t.pos_b) & 32'h0000_03FF);
            if (t.run_length == 0) t.run_length = 32'h400;
            t.last = 1'b0;
            pending_triples.push_back(t);
            list_seen.push_back(t);
        end
        for (k = 0; k < 2; k++) begin
            pending_triples.push_back(triple_t'{$urandom, $urandom, $urandom | 32'h1, 1'b0});
        end
        for (k = 0; k < 3; k++) begin
            pending_triples.push_back(list_seen[$urandom_range(0, list_seen.size() - 1)]);
        end
        pending_triples.push_back(triple_t'{$urandom, $urandom, 32'h0, 1'b0});
        pending_triples.push_back(triple_t'{$urandom, $urandom, $urandom | 32'h1, 1'b1});

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            list_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
            list_seen.delete();
            for (j = 0; j < list_len; j++) begin
                pick         = $urandom_range(0, 99);
                t.pos_a      = $urandom;
                t.pos_b      = $urandom;
                t.run_length = $urandom;
                if ($urandom_range(0, 3) == 0) begin
                    t.pos_a = $urandom_range(0, 15);
                    t.pos_b = $urandom_range(0, 15);
                end
                if (list_seen.size() > 0 && pick < 30) begin
                    t = list_seen[$urandom_range(0, list_seen.size() - 1)];
                end else if (pick < 40) begin
                    t.run_length = 32'h0;
                end else if (list_seen.size() > 0 && pick < 65) begin
                    // same home slot as an earlier triple: force a probe
                    base = list_seen[$urandom_range(0, list_seen.size() - 1)];
                    key  = base.pos_a + base.pos_b + base.run_length;
                    if (pick < 52) begin
                        t.pos_a = base.pos_a;
                        t.pos_b = base.pos_b;
                    end
                    t.run_length = {t.run_length[31:10], 10'(key - t.pos_a - t.pos_b)};
                    if (t.run_length == 0) t.run_length = 32'h400;
                end
                t.last = (j == list_len - 1);
                pending_triples.push_back(t);
                if (t.run_length != 0) list_seen.push_back(t);
                random_items++;
            end
        end
        total_beats = pending_triples.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_beats < total_beats || expected_verdicts.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("hash_dedup_filter_core regression: pass");
        end else begin
            $display("hash_dedup_filter_core regression: fail");
        end
        $finish;
    end

endmodule
